// ===== src/fsbe_pkg.sv =====
// ----------------------------------------------------------------------------
// fsbe_pkg
// Shared opcodes, status codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package fsbe_pkg;

	typedef enum logic [2:0] {
		OPC_RET   = 3'd0,
		OPC_ADD   = 3'd1,
		OPC_SUB   = 3'd2,
		OPC_MUL   = 3'd3,
		OPC_DIV   = 3'd4,
		OPC_NEG   = 3'd5,
		OPC_CONST = 3'd6
	} opcode_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
	localparam logic [62:0] INF_MAG   = 63'h7FF0_0000_0000_0000;
	localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

	// stack read address: top entry or the one below it
	typedef enum logic {
		RD_TOP,
		RD_SECOND
	} rd_sel_t;

	// stack write source and address
	typedef enum logic [1:0] {
		WR_PUSH,
		WR_NEG,
		WR_ARITH
	} wr_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLEAR
	} cnt_op_t;

	typedef struct packed {
		logic       take;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       wr_en;
		wr_sel_t    wr_sel;
		logic       hold_b;
		logic       fpu_start;
		cnt_op_t    cnt_op;
		logic       emit;
		logic       emit_val;
		logic [1:0] emit_status;
	} fsbe_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       cnt_zero;
		logic       cnt_lt2;
		logic       cnt_full;
		logic       fpu_done;
		logic       out_busy;
	} fsbe_stat_t;

endpackage

// ===== src/fp_stack_bytecode_executor.sv =====
// ----------------------------------------------------------------------------
// fp_stack_bytecode_executor
// Stack-machine interpreter over binary64 values.
// ----------------------------------------------------------------------------
// One instruction per input beat (opcode in s_tuser, constant in s_tdata).
// Constant pushes, negate flips the sign of the top, add/sub/mul/div pop b
// then a and push a op b, return pops the top, sends it out and empties the
// stack. Underflow and overflow send a zero value with an error status and
// leave the stack alone. Constant and unused opcodes end at decode, negate
// adds a write-back step, and return and errors wait while the output is
// stalled. Multiply and divide run the FPU iterations: 53 multiply steps or
// 57 divide steps (one quotient bit per cycle), plus up to 52 pre-normalize
// steps for subnormal operands and the normalize/denormalize steps. Add/sub
// run only the normalize steps, and special operands (zero, inf, NaN) skip
// them. The divide sets the worst case. The stack is a single-port-read
// memory of STACK_DEPTH entries with registered read data; no clearing pass
// is needed because only entries below the count are read. The result
// register lets the next instruction be taken while a result beat waits on
// m_tready.
// ----------------------------------------------------------------------------
module fp_stack_bytecode_executor #(
	parameter int STACK_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] operand_bits
	input  logic [2:0]  s_tuser,   // [2:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] value_bits
	output logic [1:0]  m_tuser    // [1:0] status
);

	fsbe_pkg::fsbe_cmd_t  cmd;
	fsbe_pkg::fsbe_stat_t stat;

	// sequencer: one state per step of an instruction
	fsbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stack, count, FPU and output beat register
	fsbe_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_valid   (s_tvalid),
		.in_cmd     (s_tuser),
		.in_operand (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_status (m_tuser)
	);

endmodule

// ===== src/fsbe_fpu.sv =====
// ----------------------------------------------------------------------------
// fsbe_fpu
// Iterative binary64 add/sub/mul/div, round to nearest even.
// ----------------------------------------------------------------------------
module fsbe_fpu (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  fsbe_pkg::opcode_t   op,
	input  logic [63:0]         a,
	input  logic [63:0]         b,
	output logic                done,
	output logic [63:0]         result
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_CHK,
		F_PRE,
		F_MUL,
		F_DIV,
		F_PACK,
		F_NORM,
		F_DONE
	} fstate_t;

	fstate_t            state_q;
	fsbe_pkg::opcode_t  op_q;
	logic [63:0]        a_q, b_q, res_q;
	logic               sgn_q;
	logic [52:0]        ma_q, mb_q;
	logic signed [13:0] ea_q, eb_q, e_q;
	logic [55:0]        m_q;
	logic [106:0]       acc_q;
	logic [53:0]        rem_q;
	logic [56:0]        quo_q;
	logic [5:0]         it_q;

	// operand classification
	logic [10:0] a_exp, b_exp;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, bse, sx;
	logic        spec;
	logic [63:0] spec_val;

	assign a_exp  = a_q[62:52];
	assign b_exp  = b_q[62:52];
	assign a_nan  = (a_exp == 11'h7FF) && (a_q[51:0] != '0);
	assign b_nan  = (b_exp == 11'h7FF) && (b_q[51:0] != '0);
	assign a_inf  = (a_q[62:0] == fsbe_pkg::INF_MAG);
	assign b_inf  = (b_q[62:0] == fsbe_pkg::INF_MAG);
	assign a_zero = (a_q[62:0] == '0);
	assign b_zero = (b_q[62:0] == '0);
	assign bse    = b_q[63] ^ (op_q == fsbe_pkg::OPC_SUB);
	assign sx     = a_q[63] ^ b_q[63];

	always_comb begin
		spec     = 1'b1;
		spec_val = '0;
		if (a_nan || b_nan) begin
			spec_val = fsbe_pkg::CANON_NAN;
		end else if (op_q == fsbe_pkg::OPC_ADD || op_q == fsbe_pkg::OPC_SUB) begin
			priority if (a_inf && b_inf) begin
				spec_val = (a_q[63] != bse) ? fsbe_pkg::CANON_NAN : a_q;
			end else if (a_inf) begin
				spec_val = a_q;
			end else if (b_inf) begin
				spec_val = {bse, b_q[62:0]};
			end else if (a_zero && b_zero) begin
				spec_val = {a_q[63] & bse, 63'd0};
			end else if (a_zero) begin
				spec_val = {bse, b_q[62:0]};
			end else if (b_zero) begin
				spec_val = a_q;
			end else begin
				spec = 1'b0;
			end
		end else if (op_q == fsbe_pkg::OPC_MUL) begin
			priority if ((a_inf && b_zero) || (a_zero && b_inf)) begin
				spec_val = fsbe_pkg::CANON_NAN;
			end else if (a_inf || b_inf) begin
				spec_val = {sx, fsbe_pkg::INF_MAG};
			end else if (a_zero || b_zero) begin
				spec_val = {sx, 63'd0};
			end else begin
				spec = 1'b0;
			end
		end else begin
			priority if (b_zero) begin
				spec_val = a_zero ? fsbe_pkg::CANON_NAN : {sx, fsbe_pkg::INF_MAG};
			end else if (a_inf && b_inf) begin
				spec_val = fsbe_pkg::CANON_NAN;
			end else if (a_inf) begin
				spec_val = {sx, fsbe_pkg::INF_MAG};
			end else if (b_inf || a_zero) begin
				spec_val = {sx, 63'd0};
			end else begin
				spec = 1'b0;
			end
		end
	end

	// add path: align smaller magnitude, add or subtract
	logic        swap, eff_sub, big_sgn;
	logic [63:0] big, sml;
	logic [55:0] big_m, sml_m, al, mask;
	logic [10:0] big_e, sml_e, diff;
	logic [56:0] sum57;
	logic [55:0] add_m;
	logic [13:0] add_e;

	always_comb begin
		swap    = b_q[62:0] > a_q[62:0];
		big     = swap ? b_q : a_q;
		sml     = swap ? a_q : b_q;
		big_sgn = swap ? bse : a_q[63];
		eff_sub = a_q[63] ^ bse;
		big_m   = {big[62:52] != 11'd0, big[51:0], 3'b000};
		sml_m   = {sml[62:52] != 11'd0, sml[51:0], 3'b000};
		big_e   = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
		sml_e   = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
		diff    = big_e - sml_e;
		mask    = (56'd1 << diff[5:0]) - 56'd1;
		if (diff >= 11'd56) begin
			al = {55'd0, |sml_m};
		end else begin
			al = (sml_m >> diff[5:0]) | {55'd0, |(sml_m & mask)};
		end
		sum57 = eff_sub ? ({1'b0, big_m} - {1'b0, al}) : ({1'b0, big_m} + {1'b0, al});
		if (sum57[56]) begin
			add_m = {sum57[56:2], sum57[1] | sum57[0]};
			add_e = {3'd0, big_e} + 14'd1;
		end else begin
			add_m = sum57[55:0];
			add_e = {3'd0, big_e};
		end
	end

	// multiply step, divide step
	logic [54:0]  mtmp;
	logic         dge;
	logic [53:0]  drem;

	assign mtmp = {1'b0, acc_q[106:53]} + (mb_q[0] ? {2'b00, ma_q} : 55'd0);
	assign dge  = rem_q >= {1'b0, mb_q};
	assign drem = dge ? (rem_q - {1'b0, mb_q}) : rem_q;

	// rounding
	logic        rup;
	logic [53:0] rsum;
	logic signed [13:0] rex;

	always_comb begin
		rup  = m_q[2] & (m_q[1] | m_q[0] | m_q[3]);
		rsum = {1'b0, m_q[55:3]} + {53'd0, rup};
		if (rsum[53]) begin
			rex = e_q + 14'sd1;
		end else begin
			rex = rsum[52] ? e_q : 14'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						op_q    <= op;
						a_q     <= a;
						b_q     <= b;
						state_q <= F_CHK;
					end
				end
				F_CHK: begin
					if (spec) begin
						res_q   <= spec_val;
						state_q <= F_DONE;
					end else if (op_q == fsbe_pkg::OPC_ADD || op_q == fsbe_pkg::OPC_SUB) begin
						sgn_q   <= big_sgn;
						m_q     <= add_m;
						e_q     <= add_e;
						state_q <= F_NORM;
					end else begin
						sgn_q   <= sx;
						ma_q    <= {a_exp != 11'd0, a_q[51:0]};
						mb_q    <= {b_exp != 11'd0, b_q[51:0]};
						ea_q    <= (a_exp == 11'd0) ? 14'sd1 : $signed({3'd0, a_exp});
						eb_q    <= (b_exp == 11'd0) ? 14'sd1 : $signed({3'd0, b_exp});
						state_q <= F_PRE;
					end
				end
				F_PRE: begin
					// bring subnormal mantissas up to a leading one
					if (ma_q[52] && mb_q[52]) begin
						it_q  <= '0;
						acc_q <= '0;
						rem_q <= {1'b0, ma_q};
						quo_q <= '0;
						if (op_q == fsbe_pkg::OPC_MUL) begin
							e_q     <= ea_q + eb_q - 14'sd1023;
							state_q <= F_MUL;
						end else begin
							e_q     <= ea_q - eb_q + 14'sd1023;
							state_q <= F_DIV;
						end
					end else begin
						if (!ma_q[52]) begin
							ma_q <= {ma_q[51:0], 1'b0};
							ea_q <= ea_q - 14'sd1;
						end
						if (!mb_q[52]) begin
							mb_q <= {mb_q[51:0], 1'b0};
							eb_q <= eb_q - 14'sd1;
						end
					end
				end
				F_MUL: begin
					acc_q <= {mtmp, acc_q[52:1]};
					mb_q  <= {1'b0, mb_q[52:1]};
					it_q  <= it_q + 6'd1;
					if (it_q == 6'd52) begin
						state_q <= F_PACK;
					end
				end
				F_DIV: begin
					rem_q <= {drem[52:0], 1'b0};
					quo_q <= {quo_q[55:0], dge};
					it_q  <= it_q + 6'd1;
					if (it_q == 6'd56) begin
						state_q <= F_PACK;
					end
				end
				F_PACK: begin
					if (op_q == fsbe_pkg::OPC_MUL) begin
						if (acc_q[105]) begin
							m_q <= {acc_q[105:51], |acc_q[50:0]};
							e_q <= e_q + 14'sd1;
						end else begin
							m_q <= {acc_q[104:50], |acc_q[49:0]};
						end
					end else begin
						if (quo_q[56]) begin
							m_q <= {quo_q[56:2], quo_q[1] | quo_q[0] | (|rem_q)};
						end else begin
							m_q <= {quo_q[55:1], quo_q[0] | (|rem_q)};
							e_q <= e_q - 14'sd1;
						end
					end
					state_q <= F_NORM;
				end
				F_NORM: begin
					priority if (m_q == '0) begin
						res_q   <= '0;
						state_q <= F_DONE;
					end else if (e_q < -14'sd55) begin
						m_q <= {55'd0, 1'b1};
						e_q <= 14'sd1;
					end else if (e_q < 14'sd1) begin
						m_q <= {1'b0, m_q[55:2], m_q[1] | m_q[0]};
						e_q <= e_q + 14'sd1;
					end else if (!m_q[55] && e_q > 14'sd1) begin
						m_q <= {m_q[54:0], 1'b0};
						e_q <= e_q - 14'sd1;
					end else begin
						if (rex >= 14'sd2047) begin
							res_q <= {sgn_q, fsbe_pkg::INF_MAG};
						end else begin
							res_q <= {sgn_q, rex[10:0], rsum[53] ? rsum[52:1] : rsum[51:0]};
						end
						state_q <= F_DONE;
					end
				end
				F_DONE: begin
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign done   = (state_q == F_DONE);
	assign result = res_q;

endmodule

// ===== src/fsbe_datapath.sv =====
// ----------------------------------------------------------------------------
// fsbe_datapath
// Value stack, stack count, operand holding, FPU and output register.
// ----------------------------------------------------------------------------
module fsbe_datapath #(
	parameter int STACK_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fsbe_pkg::fsbe_cmd_t  cmd,
	output fsbe_pkg::fsbe_stat_t stat,
	input  logic                 in_valid,
	input  logic [2:0]           in_cmd,
	input  logic [63:0]          in_operand,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [63:0]          out_value,
	output logic [1:0]           out_status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [63:0]   mem [STACK_DEPTH];
	logic [CW-1:0] count_q;
	logic [2:0]    cmd_q;
	logic [63:0]   operand_q, rd_data_q, b_q;
	logic          out_valid_q;
	logic [63:0]   out_value_q;
	logic [1:0]    out_status_q;
	logic [CW-1:0] top_c, sec_c;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [63:0]   wr_data;
	logic          fpu_done;
	logic [63:0]   fpu_res;

	assign top_c = count_q - CW'(1);
	assign sec_c = count_q - CW'(2);

	assign rd_addr = (cmd.rd_sel == fsbe_pkg::RD_TOP) ? top_c[AW-1:0] : sec_c[AW-1:0];

	always_comb begin
		unique case (cmd.wr_sel)
			fsbe_pkg::WR_PUSH: begin
				wr_addr = count_q[AW-1:0];
				wr_data = operand_q;
			end
			fsbe_pkg::WR_NEG: begin
				wr_addr = top_c[AW-1:0];
				wr_data = rd_data_q ^ fsbe_pkg::SIGN_BIT;
			end
			default: begin
				wr_addr = sec_c[AW-1:0];
				wr_data = fpu_res;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd.hold_b) begin
			b_q <= rd_data_q;
		end
		if (cmd.take && in_valid) begin
			cmd_q     <= in_cmd;
			operand_q <= in_operand;
		end
		if (cmd.emit) begin
			out_value_q  <= cmd.emit_val ? rd_data_q : 64'd0;
			out_status_q <= cmd.emit_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.cnt_op)
				fsbe_pkg::CNT_INC:   count_q <= count_q + CW'(1);
				fsbe_pkg::CNT_DEC:   count_q <= top_c;
				fsbe_pkg::CNT_CLEAR: count_q <= '0;
				default:             count_q <= count_q;
			endcase
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	fsbe_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.fpu_start),
		.op     (fsbe_pkg::opcode_t'(cmd_q)),
		.a      (rd_data_q),
		.b      (b_q),
		.done   (fpu_done),
		.result (fpu_res)
	);

	assign stat.cmd      = cmd_q;
	assign stat.cnt_zero = (count_q == '0);
	assign stat.cnt_lt2  = (count_q < CW'(2));
	assign stat.cnt_full = (count_q == CW'(STACK_DEPTH));
	assign stat.fpu_done = fpu_done;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && !out_ready))
		else $error("result written over an untaken beat");

	a_fpu_operands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fpu_start |-> count_q >= CW'(2))
		else $error("arithmetic started without two operands");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cnt_op == fsbe_pkg::CNT_INC) |-> count_q < CW'(STACK_DEPTH))
		else $error("push on a full stack");

endmodule

// ===== src/fsbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsbe_ctrl
// Instruction sequencer: decodes one opcode and steps the datapath.
// ----------------------------------------------------------------------------
module fsbe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fsbe_pkg::fsbe_stat_t stat,
	output fsbe_pkg::fsbe_cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE,
		DECODE,
		RET_OUT,
		BIN_B,
		BIN_A,
		BIN_WAIT,
		NEG_WR,
		ERR_OUT
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] err_q, err_d;
	logic       ready_q;

	always_comb begin
		state_d         = state_q;
		err_d           = err_q;
		cmd             = '0;
		cmd.rd_sel      = fsbe_pkg::RD_TOP;
		cmd.wr_sel      = fsbe_pkg::WR_PUSH;
		cmd.cnt_op      = fsbe_pkg::CNT_HOLD;
		cmd.emit_status = fsbe_pkg::ST_OK;
		unique case (state_q)
			IDLE: begin
				cmd.take = 1'b1;
				if (in_valid) begin
					state_d = DECODE;
				end
			end
			DECODE: begin
				state_d = IDLE;
				unique case (stat.cmd)
					fsbe_pkg::OPC_RET: begin
						if (stat.cnt_zero) begin
							err_d   = fsbe_pkg::ST_UNDERFLOW;
							state_d = ERR_OUT;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = RET_OUT;
						end
					end
					fsbe_pkg::OPC_ADD, fsbe_pkg::OPC_SUB,
					fsbe_pkg::OPC_MUL, fsbe_pkg::OPC_DIV: begin
						if (stat.cnt_lt2) begin
							err_d   = fsbe_pkg::ST_UNDERFLOW;
							state_d = ERR_OUT;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = BIN_B;
						end
					end
					fsbe_pkg::OPC_NEG: begin
						if (stat.cnt_zero) begin
							err_d   = fsbe_pkg::ST_UNDERFLOW;
							state_d = ERR_OUT;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = NEG_WR;
						end
					end
					fsbe_pkg::OPC_CONST: begin
						if (stat.cnt_full) begin
							err_d   = fsbe_pkg::ST_OVERFLOW;
							state_d = ERR_OUT;
						end else begin
							cmd.wr_en  = 1'b1;
							cmd.cnt_op = fsbe_pkg::CNT_INC;
						end
					end
					default: begin
					end
				endcase
			end
			RET_OUT: begin
				if (!stat.out_busy) begin
					cmd.emit     = 1'b1;
					cmd.emit_val = 1'b1;
					cmd.cnt_op   = fsbe_pkg::CNT_CLEAR;
					state_d      = IDLE;
				end
			end
			BIN_B: begin
				cmd.hold_b = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = fsbe_pkg::RD_SECOND;
				state_d    = BIN_A;
			end
			BIN_A: begin
				cmd.fpu_start = 1'b1;
				state_d       = BIN_WAIT;
			end
			BIN_WAIT: begin
				if (stat.fpu_done) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = fsbe_pkg::WR_ARITH;
					cmd.cnt_op = fsbe_pkg::CNT_DEC;
					state_d    = IDLE;
				end
			end
			NEG_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = fsbe_pkg::WR_NEG;
				state_d    = IDLE;
			end
			ERR_OUT: begin
				if (!stat.out_busy) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = err_q;
					state_d         = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
		cmd.take = cmd.take & ready_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			err_q   <= fsbe_pkg::ST_OK;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
			ready_q <= (state_d == IDLE);
		end
	end

	assign in_ready = ready_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary64 stack-machine executor.
// ----------------------------------------------------------------------------
// Instructions go in through a bursty stream driver. A behavioral stack with
// simulator real arithmetic predicts each result beat. A monitor with a
// patterned or random back-pressure checks every result beat in order. The stimulus
// covers directed corner cases, one overflow fill, and random programs mixed
// with noise.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          DEPTH     = 256;
	localparam logic [2:0]  CMD_NONE  = 3'd7;      // unused opcode
	localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] ONE       = 64'h3FF0_0000_0000_0000;
	localparam int          CYC_LIMIT = 800000;
	localparam int          N_ITEMS   = 700;

	typedef struct {
		logic [2:0]  cmd;
		logic [63:0] operand;
		bit          drain;    // hold off until all results are back
	} instr_t;

	typedef struct {
		logic [63:0] value;
		logic [1:0]  status;
	} result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;   // [2:0] cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;         // [1:0] status

	instr_t      pending_q[$];
	result_t     result_q[$];
	logic [63:0] stk[DEPTH];
	int          stk_cnt;
	int          n_mismatch, n_taken, n_results, n_errors, cyc;

	fp_stack_bytecode_executor #(.STACK_DEPTH(DEPTH)) u_top (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic bit is_nan(logic [63:0] b);
		return b[62:0] > POS_INF[62:0];
	endfunction

	function automatic logic [63:0] fp_calc(logic [2:0] op, logic [63:0] a,
	                                        logic [63:0] b);
		real         ra, rb, rr;
		logic [63:0] res;
		ra = $bitstoreal(a);
		rb = $bitstoreal(b);
		rr = 0.0;
		// x/0 is defined here, not left to the simulator
		if (op == fsbe_pkg::OPC_DIV && b[62:0] == '0 && !is_nan(a) && !is_nan(b))
			return (a[62:0] == '0) ? fsbe_pkg::CANON_NAN :
			       (POS_INF | ((a ^ b) & fsbe_pkg::SIGN_BIT));
		case (op)
			fsbe_pkg::OPC_ADD: rr = ra + rb;
			fsbe_pkg::OPC_SUB: rr = ra - rb;
			fsbe_pkg::OPC_MUL: rr = ra * rb;
			default:           rr = ra / rb;
		endcase
		res = $realtobits(rr);
		return is_nan(res) ? fsbe_pkg::CANON_NAN : res;
	endfunction

	task automatic push_result(logic [63:0] v, logic [1:0] st);
		result_t r;
		r.value  = v;
		r.status = st;
		result_q.push_back(r);
	endtask

	task automatic execute(instr_t it);
		case (it.cmd)
			fsbe_pkg::OPC_RET: begin
				if (stk_cnt < 1) push_result('0, fsbe_pkg::ST_UNDERFLOW);
				else begin
					push_result(stk[stk_cnt-1], fsbe_pkg::ST_OK);
					stk_cnt = 0;
				end
			end
			fsbe_pkg::OPC_ADD, fsbe_pkg::OPC_SUB, fsbe_pkg::OPC_MUL, fsbe_pkg::OPC_DIV: begin
				if (stk_cnt < 2) push_result('0, fsbe_pkg::ST_UNDERFLOW);
				else begin
					stk[stk_cnt-2] = fp_calc(it.cmd, stk[stk_cnt-2], stk[stk_cnt-1]);
					stk_cnt--;
				end
			end
			fsbe_pkg::OPC_NEG: begin
				if (stk_cnt < 1) push_result('0, fsbe_pkg::ST_UNDERFLOW);
				else stk[stk_cnt-1] ^= fsbe_pkg::SIGN_BIT;
			end
			fsbe_pkg::OPC_CONST: begin
				if (stk_cnt >= DEPTH) push_result('0, fsbe_pkg::ST_OVERFLOW);
				else begin
					stk[stk_cnt] = it.operand;
					stk_cnt++;
				end
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_instr(logic [2:0] c, logic [63:0] v = '0, bit drain = 1'b0);
		instr_t it;
		it.cmd     = c;
		it.operand = v;
		it.drain   = drain;
		pending_q.push_back(it);
	endtask

	function automatic logic [63:0] rand_u64();
		return {$urandom(), $urandom()};
	endfunction

	// mostly ordinary magnitudes so arithmetic stays interesting
	function automatic logic [63:0] rand_double();
		logic [63:0] v;
		v = rand_u64();
		case ($urandom_range(0, 9))
			0: v[62:52] = 11'h000;                          // subnormal / zero
			1: v[62:52] = 11'h7FF;                          // inf / NaN
			2: v[62:0]  = '0;                               // signed zero
			3: v        = rand_u64();                       // anything
			4: v[62:52] = 11'd1 + 11'($urandom_range(0, 3)); // near subnormal
			default: v[62:52] = 11'd1013 + 11'($urandom_range(0, 20));
		endcase
		return v;
	endfunction

	task automatic gen_program();
		int depth, steps;
		depth = $urandom_range(1, 5);
		for (int i = 0; i < depth; i++) add_instr(fsbe_pkg::OPC_CONST, rand_double());
		steps = $urandom_range(0, 8);
		for (int i = 0; i < steps; i++) begin
			case ($urandom_range(0, 3))
				0: if (depth < 10) begin
					add_instr(fsbe_pkg::OPC_CONST, rand_double());
					depth++;
				end
				1: add_instr(fsbe_pkg::OPC_NEG, rand_u64());
				default: if (depth >= 2) begin
					add_instr(3'($urandom_range(fsbe_pkg::OPC_ADD, fsbe_pkg::OPC_DIV)),
					          rand_u64());
					depth--;
				end
			endcase
		end
		add_instr(fsbe_pkg::OPC_RET, rand_u64());
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		// directed: underflows, unused opcode, each op, corner values
		add_instr(fsbe_pkg::OPC_RET);
		add_instr(fsbe_pkg::OPC_NEG);
		add_instr(fsbe_pkg::OPC_ADD);
		add_instr(CMD_NONE, '1);
		add_instr(fsbe_pkg::OPC_CONST, '1);                      // NaN with payload
		add_instr(fsbe_pkg::OPC_MUL, '1);                        // one entry: underflow
		add_instr(fsbe_pkg::OPC_NEG);                            // payload kept
		add_instr(fsbe_pkg::OPC_RET);
		add_instr(fsbe_pkg::OPC_CONST, ONE);
		add_instr(fsbe_pkg::OPC_CONST, '0);
		add_instr(fsbe_pkg::OPC_DIV);                            // 1/0 -> +inf
		add_instr(fsbe_pkg::OPC_CONST, fsbe_pkg::SIGN_BIT);
		add_instr(fsbe_pkg::OPC_DIV);                            // inf/-0 -> -inf
		add_instr(fsbe_pkg::OPC_RET);
		add_instr(fsbe_pkg::OPC_CONST, '0);
		add_instr(fsbe_pkg::OPC_CONST, fsbe_pkg::SIGN_BIT);
		add_instr(fsbe_pkg::OPC_DIV);                            // 0/0 -> NaN
		add_instr(fsbe_pkg::OPC_CONST, 64'h0000_0000_0000_0001); // min subnormal
		add_instr(fsbe_pkg::OPC_ADD);                            // NaN + x
		add_instr(fsbe_pkg::OPC_CONST, 64'h7FEF_FFFF_FFFF_FFFF);
		add_instr(fsbe_pkg::OPC_SUB);
		add_instr(fsbe_pkg::OPC_RET);
		add_instr(fsbe_pkg::OPC_RET);
		// fill the stack, then one push too many
		for (int i = 0; i <= DEPTH; i++) add_instr(fsbe_pkg::OPC_CONST, rand_u64(), i == 0);
		add_instr(fsbe_pkg::OPC_RET, '0, 1'b1);
		// random programs with some noise and occasional full drains
		while (pending_q.size() < N_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				add_instr(3'($urandom_range(0, 7)), rand_u64());
			else
				gen_program();
			if ($urandom_range(0, 30) == 0)
				add_instr(fsbe_pkg::OPC_CONST, rand_double(), 1'b1);
		end
	end

	// reset
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// driver: bursts with random gaps
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		instr_t nxt;
		bit     load;
		if (arst_n) begin
			load = 1'b0;
			if (s_tvalid && s_tready) begin
				execute('{s_tuser, s_tdata, 1'b0});
				n_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) gap_left--;
				else if (pending_q.size() > 0 &&
				         (!pending_q[0].drain || (result_q.size() == 0 && !s_tvalid))) begin
					nxt  = pending_q.pop_front();
					load = 1'b1;
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 30);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
				s_tvalid <= load;
				if (load) begin
					s_tuser <= nxt.cmd;
					s_tdata <= nxt.operand;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor with its own stall pattern
	// ------------------------------------------------------------------
	logic [15:0] stall_pat  = 16'hA5C3;
	int          stall_mode = 0;

	task automatic report(string what, logic [63:0] got, logic [63:0] exp_v);
		$display("ERROR @%0t: %s got %h expected %h", $realtime, what, got, exp_v);
		n_mismatch++;
	endtask

	always @(posedge clk) begin
		result_t r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (result_q.size() == 0) report("unexpected result beat", m_tdata, '0);
				else begin
					r = result_q.pop_front();
					if (r.status != fsbe_pkg::ST_OK) n_errors++;
					if (m_tdata !== r.value) report("value_bits", m_tdata, r.value);
					if (m_tuser !== r.status)
						report("status", 64'(m_tuser), 64'(r.status));
				end
			end
			if (cyc % 128 == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_pat  = 16'($urandom());
			end
			stall_pat = {stall_pat[14:0], stall_pat[15]};
			case (stall_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= stall_pat[0];
				2:       m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYC_LIMIT) begin
			$display("Timeout after %0d cycles", cyc);
			$display("Mismatches found");
			$finish;
		end
	end

	// end of run
	initial begin
		@(posedge arst_n);
		do @(posedge clk);
		while (pending_q.size() != 0 || s_tvalid || result_q.size() != 0);
		repeat (400) @(posedge clk);
		$display("Ran %0d instructions, checked %0d result beats (%0d error status)",
		         n_taken, n_results, n_errors);
		if (n_mismatch == 0 && result_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/fsbe_pkg.sv
src/fsbe_fpu.sv
src/fsbe_datapath.sv
src/fsbe_ctrl.sv
src/fp_stack_bytecode_executor.sv
tb/tb_top.sv
